// ===== src/pls_pkg.sv =====
package pls_pkg;

    // List geometry.
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    // Request types.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_SH_RD = 6'b000100,
        S_SH_WR = 6'b001000,
        S_LOAD  = 6'b010000,
        S_DONE  = 6'b100000
    } seq_state_t;

endpackage

// ===== src/positional_list_store.sv =====
// An error or no-op request goes straight to S_DONE and a read passes through S_RD; an insert
// moves k entries and then writes the new value in S_LOAD, and a delete moves k entries.
// One request at a time: req_stall stays high until the result is registered. Each moved entry
// costs one RAM read and one RAM write on the single-port-pair RAM.
// Reset (rst_n low, asynchronous) empties the list and clears the response valid flag;
// the entry RAM is not cleared, since no position at or beyond the count is ever read.
module positional_list_store (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel.
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          req_type,
    input  logic [pls_pkg::POS_W-1:0]           position,
    input  logic signed [pls_pkg::DATA_W-1:0]   new_value,
    // Response channel.
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [pls_pkg::DATA_W-1:0]   read_value,
    output logic [1:0]                          status,
    output logic [pls_pkg::CNT_W-1:0]           entry_count
);

    // Sequencer and working registers. The list is kept in a RAM in position order;
    // insert and delete move entries one at a time through the RAM's registered read port.
    pls_pkg::seq_state_t state_reg, state_next;
    logic [pls_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       ins_reg, ins_next;
    logic [pls_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [pls_pkg::ADDR_W-1:0] lim_reg, lim_next;
    logic [pls_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [pls_pkg::DATA_W-1:0] val_reg, val_next;
    logic [pls_pkg::DATA_W-1:0] res_value_reg, res_value_next;
    logic [1:0]                 res_status_reg, res_status_next;

    // Response register.
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [pls_pkg::DATA_W-1:0] read_value_reg;
    logic [1:0]                 status_reg;
    logic [pls_pkg::CNT_W-1:0]  entry_count_reg;

    // Shared step unit: one increment or decrement of the walking index.
    logic [pls_pkg::ADDR_W-1:0] idx_step;
    logic                       at_limit;

    logic                       req_accept;
    logic                       rsp_load;

    logic                       ram_we;
    logic [pls_pkg::ADDR_W-1:0] ram_waddr;
    logic [pls_pkg::DATA_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [pls_pkg::ADDR_W-1:0] ram_raddr;
    logic [pls_pkg::DATA_W-1:0] ram_rdata;

    pls_ram #(
        .WIDTH(pls_pkg::DATA_W),
        .DEPTH(pls_pkg::CAPACITY)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req_stall  = (state_reg != pls_pkg::S_IDLE);
    assign req_accept = req_valid && !req_stall;

    // Insert walks downward from the old tail, delete walks upward from the hole.
    assign idx_step = ins_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
    assign at_limit = (idx_reg == lim_reg);

    // The response register can be loaded when it is empty or being drained.
    assign rsp_load = (state_reg == pls_pkg::S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ins_next        = ins_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_step;

        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (req_accept)
                begin
                    res_value_next  = '0;
                    res_status_next = pls_pkg::ST_OK;
                    pos_next        = position[pls_pkg::ADDR_W-1:0];
                    val_next        = new_value;
                    state_next      = pls_pkg::S_DONE;
                    unique case (req_type)
                        pls_pkg::REQ_INSERT:
                        begin
                            ins_next = 1'b1;
                            if (position > count_reg)
                            begin
                                res_status_next = pls_pkg::ST_BAD_POS;
                            end
                            else if (count_reg >= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
                            begin
                                res_status_next = pls_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                // Entries from the tail down to position move up first.
                                idx_next   = count_reg[pls_pkg::ADDR_W-1:0];
                                lim_next   = position[pls_pkg::ADDR_W-1:0] + 1'b1;
                                if (position == count_reg)
                                begin
                                    state_next = pls_pkg::S_LOAD;
                                end
                                else
                                begin
                                    state_next = pls_pkg::S_SH_RD;
                                end
                            end
                        end
                        pls_pkg::REQ_READ:
                        begin
                            if (position >= count_reg)
                            begin
                                res_status_next = pls_pkg::ST_BAD_POS;
                                res_value_next  = '1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = position[pls_pkg::ADDR_W-1:0];
                                state_next = pls_pkg::S_RD;
                            end
                        end
                        pls_pkg::REQ_DELETE:
                        begin
                            ins_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                res_status_next = pls_pkg::ST_EMPTY;
                            end
                            else if (position >= count_reg)
                            begin
                                res_status_next = pls_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                // Entries above the hole move down, the last write lands
                                // at count-2.
                                idx_next   = position[pls_pkg::ADDR_W-1:0];
                                lim_next   = pls_pkg::ADDR_W'(count_reg - 5'd2);
                                if (position != count_reg - 1'b1)
                                begin
                                    state_next = pls_pkg::S_SH_RD;
                                end
                            end
                        end
                        default:
                        begin
                            // Unused request type: no change, status ok.
                        end
                    endcase
                end
            end
            pls_pkg::S_RD:
            begin
                res_value_next = ram_rdata;
                state_next     = pls_pkg::S_DONE;
            end
            pls_pkg::S_SH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_step;
                state_next = pls_pkg::S_SH_WR;
            end
            pls_pkg::S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_step;
                if (at_limit)
                begin
                    state_next = ins_reg ? pls_pkg::S_LOAD : pls_pkg::S_DONE;
                end
                else
                begin
                    state_next = pls_pkg::S_SH_RD;
                end
            end
            pls_pkg::S_LOAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                state_next = pls_pkg::S_DONE;
            end
            pls_pkg::S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pls_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg        <= ins_next;
        idx_reg        <= idx_next;
        lim_reg        <= lim_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (rsp_load)
        begin
            read_value_reg  <= res_value_reg;
            status_reg      <= res_status_reg;
            entry_count_reg <= count_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    // The entry RAM is written only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != pls_pkg::S_IDLE))
        else $error("RAM write while idle");

    // An accepted request leaves the idle state on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg != pls_pkg::S_IDLE))
        else $error("sequencer did not start on an accepted request");

    // An empty status always reports an empty list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == pls_pkg::ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

// ===== src/pls_ram.sv =====
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
